@@ rtl/core/r2q_pkg.sv @@
`timescale 1ns / 1ps
package r2q_pkg;

  // Word format of the matrix elements and of the quaternion.
  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;

  // Pair sums of off-diagonal elements and trace combinations.
  localparam int SUM_BITS  = WORD_BITS + 1;
  localparam int COMB_BITS = WORD_BITS + 2;

  // Radicand (combination plus one, scaled) and its square root.
  localparam int V_BITS     = WORD_BITS + 1;
  localparam int ROOT_STEPS = (V_BITS + FRAC_BITS - 2 + 1) / 2;
  localparam int ROOT_BITS  = ROOT_STEPS;
  localparam int RAD_BITS   = 2 * ROOT_STEPS;

  // Dividend of the divider lanes: magnitude scaled plus half the divisor.
  localparam int NUM_BITS = WORD_BITS + FRAC_BITS - 1;

  localparam int ONE_VAL = 1 << FRAC_BITS;

  localparam logic [WORD_BITS-1:0] SMAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Which quaternion component is the largest.
  typedef enum logic [1:0] {
    COMP_W,
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_t;

  // Data that travels along the square root cells.
  typedef struct packed {
    logic                       valid;
    comp_t                      idx;
    logic signed [SUM_BITS-1:0] s0;
    logic signed [SUM_BITS-1:0] s1;
    logic signed [SUM_BITS-1:0] s2;
  } side_t;

  // State of one divider lane inside one cell.
  typedef struct packed {
    logic [NUM_BITS-1:0]  num;
    logic [NUM_BITS-1:0]  quo;
    logic [ROOT_BITS-1:0] rem;
    logic                 neg;
    logic                 nz;
  } lane_t;

  // Data that travels alongside the divider cells.
  typedef struct packed {
    comp_t                idx;
    logic [ROOT_BITS-1:0] big;
  } meta_t;

endpackage

@@ rtl/core/rotation_to_quaternion.sv @@
`timescale 1ns / 1ps
// Converts a rotation matrix to a unit quaternion by the largest-component method. One
// matrix beat is taken every cycle while the pipeline moves. An input stage forms and picks
// the trace combinations, a row of 15 square root cells produces one root bit each, three
// lanes of 29 divider cells produce one quotient bit each, and an output stage saturates
// and registers the result. When the result beat is stalled the whole pipeline holds;
// otherwise a new matrix enters each cycle.
module rotation_to_quaternion (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r00,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r01,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r02,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r10,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r11,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r12,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r20,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r21,
  input  logic signed [r2q_pkg::WORD_BITS-1:0] in_r22,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [r2q_pkg::WORD_BITS-1:0] out_quat_x,
  output logic signed [r2q_pkg::WORD_BITS-1:0] out_quat_y,
  output logic signed [r2q_pkg::WORD_BITS-1:0] out_quat_z,
  output logic signed [r2q_pkg::WORD_BITS-1:0] out_quat_w,
  output logic                                 out_degenerate
);
  import r2q_pkg::*;

  logic adv;

  logic signed [COMB_BITS-1:0] cw, cx, cy, cz, best, v;
  logic signed [SUM_BITS-1:0]  dx, dy, dz, px, py, pz;
  side_t                       side_nxt;
  logic [RAD_BITS-1:0]         rad_nxt;
  logic                        s0_valid_r;
  side_t                       s0_side_r;
  logic [RAD_BITS-1:0]         s0_rad_r;
  side_t                       s0_side;

  side_t                sq_side [ROOT_STEPS];
  logic [RAD_BITS-1:0]  sq_rad  [ROOT_STEPS];
  logic [ROOT_BITS:0]   sq_rem  [ROOT_STEPS];
  logic [ROOT_BITS-1:0] sq_root [ROOT_STEPS];

  side_t                sq_last;
  logic [ROOT_BITS-1:0] big;
  lane_t                lane_init [3];
  lane_t                ln [3][NUM_BITS];
  meta_t                meta_r [NUM_BITS];
  logic                 vld_r  [NUM_BITS];

  meta_t                  meta_last;
  logic                   degen;
  logic [WORD_BITS-1:0]   res [3];
  logic [WORD_BITS-1:0]   bigv;
  logic [WORD_BITS-1:0]   qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic                   out_valid_r;
  logic [WORD_BITS-1:0]   qx_r, qy_r, qz_r, qw_r;
  logic                   degen_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Trace combinations, off-diagonal pair terms and choice of the largest.
  always_comb begin
    cw = COMB_BITS'(in_r00) + COMB_BITS'(in_r11) + COMB_BITS'(in_r22);
    cx = COMB_BITS'(in_r00) - COMB_BITS'(in_r11) - COMB_BITS'(in_r22);
    cy = COMB_BITS'(in_r11) - COMB_BITS'(in_r00) - COMB_BITS'(in_r22);
    cz = COMB_BITS'(in_r22) - COMB_BITS'(in_r00) - COMB_BITS'(in_r11);
    dx = SUM_BITS'(in_r21) - SUM_BITS'(in_r12);
    dy = SUM_BITS'(in_r02) - SUM_BITS'(in_r20);
    dz = SUM_BITS'(in_r10) - SUM_BITS'(in_r01);
    px = SUM_BITS'(in_r10) + SUM_BITS'(in_r01);
    py = SUM_BITS'(in_r02) + SUM_BITS'(in_r20);
    pz = SUM_BITS'(in_r21) + SUM_BITS'(in_r12);
    side_nxt.valid = in_valid;
    side_nxt.idx   = COMP_W;
    best           = cw;
    if (cx > best) begin
      best         = cx;
      side_nxt.idx = COMP_X;
    end
    if (cy > best) begin
      best         = cy;
      side_nxt.idx = COMP_Y;
    end
    if (cz > best) begin
      best         = cz;
      side_nxt.idx = COMP_Z;
    end
    unique case (side_nxt.idx)
      COMP_W: begin
        side_nxt.s0 = dx;
        side_nxt.s1 = dy;
        side_nxt.s2 = dz;
      end
      COMP_X: begin
        side_nxt.s0 = px;
        side_nxt.s1 = py;
        side_nxt.s2 = dx;
      end
      COMP_Y: begin
        side_nxt.s0 = px;
        side_nxt.s1 = pz;
        side_nxt.s2 = dy;
      end
      default: begin
        side_nxt.s0 = py;
        side_nxt.s1 = pz;
        side_nxt.s2 = dz;
      end
    endcase
    v = best + COMB_BITS'(ONE_VAL);
    if (v < 0) begin
      rad_nxt = '0;
    end else begin
      rad_nxt = RAD_BITS'({v[V_BITS-1:0], {(FRAC_BITS-2){1'b0}}});
    end
  end

  // Input stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= side_nxt;
      s0_rad_r  <= rad_nxt;
    end
  end

  always_comb begin
    s0_side       = s0_side_r;
    s0_side.valid = s0_valid_r;
  end

  // Row of square root cells, one root bit per cell.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      r2q_sqrt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .side_i (s0_side),
        .rad_i  (s0_rad_r),
        .rem_i  ('0),
        .root_i ('0),
        .side_o (sq_side[k]),
        .rad_o  (sq_rad[k]),
        .rem_o  (sq_rem[k]),
        .root_o (sq_root[k])
      );
    end else begin : g_next
      r2q_sqrt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .side_i (sq_side[k-1]),
        .rad_i  (sq_rad[k-1]),
        .rem_i  (sq_rem[k-1]),
        .root_i (sq_root[k-1]),
        .side_o (sq_side[k]),
        .rad_o  (sq_rad[k]),
        .rem_o  (sq_rem[k]),
        .root_o (sq_root[k])
      );
    end
  end

  assign sq_last = sq_side[ROOT_STEPS-1];
  assign big     = sq_root[ROOT_STEPS-1];

  // Dividends: magnitude scaled by a quarter unit plus half the divisor.
  always_comb begin
    logic signed [SUM_BITS-1:0] s   [3];
    logic signed [SUM_BITS-1:0] mag [3];
    s[0] = sq_last.s0;
    s[1] = sq_last.s1;
    s[2] = sq_last.s2;
    for (int l = 0; l < 3; l++) begin
      mag[l]          = s[l][SUM_BITS-1] ? -s[l] : s[l];
      lane_init[l].num = NUM_BITS'({mag[l][SUM_BITS-1:0], {(FRAC_BITS-2){1'b0}}})
                       + NUM_BITS'(big >> 1);
      lane_init[l].quo = '0;
      lane_init[l].rem = '0;
      lane_init[l].neg = s[l][SUM_BITS-1];
      lane_init[l].nz  = s[l] != '0;
    end
  end

  // Three lanes of divider cells, one quotient bit per cell.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar k = 0; k < NUM_BITS; k++) begin : g_div
      if (k == 0) begin : g_first
        r2q_div_cell u_cell (
          .clk    (clk),
          .en     (adv),
          .div_i  (big),
          .lane_i (lane_init[l]),
          .lane_o (ln[l][k])
        );
      end else begin : g_next
        r2q_div_cell u_cell (
          .clk    (clk),
          .en     (adv),
          .div_i  (meta_r[k-1].big),
          .lane_i (ln[l][k-1]),
          .lane_o (ln[l][k])
        );
      end
    end
  end

  // Component choice and divisor travel beside the divider cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_BITS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= sq_last.valid;
      for (int k = 1; k < NUM_BITS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0].idx <= sq_last.idx;
      meta_r[0].big <= big;
      for (int k = 1; k < NUM_BITS; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // Rounding is already in the dividend; saturate and place the components.
  always_comb begin
    lane_t fl;
    meta_last = meta_r[NUM_BITS-1];
    degen     = meta_last.big == '0;
    for (int l = 0; l < 3; l++) begin
      fl = ln[l][NUM_BITS-1];
      if (degen) begin
        if (!fl.nz) begin
          res[l] = '0;
        end else begin
          res[l] = fl.neg ? SMIN_W : SMAX_W;
        end
      end else if (fl.neg) begin
        if (fl.quo > NUM_BITS'(SMIN_W)) begin
          res[l] = SMIN_W;
        end else begin
          res[l] = -fl.quo[WORD_BITS-1:0];
        end
      end else begin
        if (fl.quo > NUM_BITS'(SMAX_W)) begin
          res[l] = SMAX_W;
        end else begin
          res[l] = fl.quo[WORD_BITS-1:0];
        end
      end
    end
    if ((WORD_BITS + ROOT_BITS)'(meta_last.big) > (WORD_BITS + ROOT_BITS)'(SMAX_W)) begin
      bigv = SMAX_W;
    end else begin
      bigv = WORD_BITS'(meta_last.big);
    end
    unique case (meta_last.idx)
      COMP_W: begin
        qx_nxt = res[0];
        qy_nxt = res[1];
        qz_nxt = res[2];
        qw_nxt = bigv;
      end
      COMP_X: begin
        qx_nxt = bigv;
        qy_nxt = res[0];
        qz_nxt = res[1];
        qw_nxt = res[2];
      end
      COMP_Y: begin
        qx_nxt = res[0];
        qy_nxt = bigv;
        qz_nxt = res[1];
        qw_nxt = res[2];
      end
      default: begin
        qx_nxt = res[0];
        qy_nxt = res[1];
        qz_nxt = bigv;
        qw_nxt = res[2];
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NUM_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      qz_r    <= qz_nxt;
      qw_r    <= qw_nxt;
      degen_r <= degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_x     = qx_r;
  assign out_quat_y     = qy_r;
  assign out_quat_z     = qz_r;
  assign out_quat_w     = qw_r;
  assign out_degenerate = degen_r;

  // The root leaving the last cell is a floor square root.
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_last.valid |-> (sq_rem[ROOT_STEPS-1] <= {big, 1'b0}))
    else $error("square root remainder exceeds twice the root");

  // The largest combination is never negative, so the root is never zero.
  a_no_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_degenerate)
    else $error("degenerate result on a valid beat");

  // A held pipeline keeps its last stage.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r[NUM_BITS-1]))
    else $error("divider stage moved while stalled");

  // An accepted matrix lands in the input stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s0_valid_r)
    else $error("accepted matrix lost at input stage");

endmodule

@@ rtl/core/r2q_sqrt_cell.sv @@
`timescale 1ns / 1ps
module r2q_sqrt_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  r2q_pkg::side_t                     side_i,
  input  logic [r2q_pkg::RAD_BITS-1:0]       rad_i,
  input  logic [r2q_pkg::ROOT_BITS:0]        rem_i,
  input  logic [r2q_pkg::ROOT_BITS-1:0]      root_i,
  output r2q_pkg::side_t                     side_o,
  output logic [r2q_pkg::RAD_BITS-1:0]       rad_o,
  output logic [r2q_pkg::ROOT_BITS:0]        rem_o,
  output logic [r2q_pkg::ROOT_BITS-1:0]      root_o
);
  import r2q_pkg::*;

  logic [ROOT_BITS+2:0] rem_sh;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 ge;
  logic [ROOT_BITS:0]   rem_nxt;
  logic [ROOT_BITS-1:0] root_nxt;
  logic [RAD_BITS-1:0]  rad_nxt;
  logic                 valid_r;
  side_t                side_r;
  logic [RAD_BITS-1:0]  rad_r;
  logic [ROOT_BITS:0]   rem_r;
  logic [ROOT_BITS-1:0] root_r;

  // One result bit: bring down two radicand bits and try 4*root+1.
  always_comb begin
    rem_sh   = {rem_i, rad_i[RAD_BITS-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = rem_sh >= trial;
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
    root_nxt = {root_i[ROOT_BITS-2:0], ge};
    rad_nxt  = {rad_i[RAD_BITS-3:0], 2'b00};
  end

  // Valid flag of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= side_i.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_comb begin
    side_o       = side_r;
    side_o.valid = valid_r;
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

@@ rtl/core/r2q_div_cell.sv @@
`timescale 1ns / 1ps
module r2q_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [r2q_pkg::ROOT_BITS-1:0] div_i,
  input  r2q_pkg::lane_t                lane_i,
  output r2q_pkg::lane_t                lane_o
);
  import r2q_pkg::*;

  logic [ROOT_BITS:0] rem_sh;
  logic [ROOT_BITS:0] diff;
  logic               ge;
  lane_t              lane_nxt;
  lane_t              lane_r;

  // One quotient bit of a restoring division.
  always_comb begin
    rem_sh       = {lane_i.rem, lane_i.num[NUM_BITS-1]};
    ge           = rem_sh >= {1'b0, div_i};
    diff         = rem_sh - {1'b0, div_i};
    lane_nxt     = lane_i;
    lane_nxt.rem = ge ? diff[ROOT_BITS-1:0] : rem_sh[ROOT_BITS-1:0];
    lane_nxt.num = {lane_i.num[NUM_BITS-2:0], 1'b0};
    lane_nxt.quo = {lane_i.quo[NUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import r2q_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // One quaternion beat as the block should return it.
  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  deg;
  } quat_t;

  // One row of the directed stimulus; known marks a result typed in by hand.
  typedef struct {
    word_t m [9];
    bit    known;
    quat_t q;
  } row_t;

  localparam int N_RANDOM = 630;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t mat [9] = '{default: '0};
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  logic  out_degenerate;

  quat_t pending_quats[$];
  int    errors = 0;
  int    cycle = 0;
  bit    sending_done = 1'b0;

  always #5 clk = ~clk;

  rotation_to_quaternion uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r00(mat[0]), .in_r01(mat[1]), .in_r02(mat[2]),
    .in_r10(mat[3]), .in_r11(mat[4]), .in_r12(mat[5]),
    .in_r20(mat[6]), .in_r21(mat[7]), .in_r22(mat[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_degenerate(out_degenerate)
  );

  // Floor of the square root, one result bit per step.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Quarter of a pair sum over the largest component, rounded half away from zero.
  function automatic word_t scaled_quotient(longint s, longint unsigned big);
    longint unsigned mag, q;
    longint          smax, smin;
    smax = (longint'(1) << (WORD_BITS - 1)) - 1;
    smin = -(longint'(1) << (WORD_BITS - 1));
    if (big == 0) begin
      if (s > 0) return word_t'(smax);
      if (s < 0) return word_t'(smin);
      return '0;
    end
    mag = (s < 0) ? longint'(-s) : s;
    q = ((mag << (FRAC_BITS - 2)) + (big >> 1)) / big;
    if (s < 0) begin
      if (q > longint'(-smin)) return word_t'(smin);
      return word_t'(-longint'(q));
    end
    if (q > smax) return word_t'(smax);
    return word_t'(q);
  endfunction

  // Largest-component conversion of one matrix.
  function automatic quat_t shepperd_quat(word_t m [9]);
    longint          e [9];
    longint          cw, cx, cy, cz, best, v, smax;
    longint unsigned big;
    comp_t           pick;
    word_t           bigw;
    quat_t           r;
    for (int i = 0; i < 9; i++) e[i] = m[i];
    smax = (longint'(1) << (WORD_BITS - 1)) - 1;
    cw = e[0] + e[4] + e[8];
    cx = e[0] - e[4] - e[8];
    cy = e[4] - e[0] - e[8];
    cz = e[8] - e[0] - e[4];
    best = cw;
    pick = COMP_W;
    // Strict comparison so that ties keep the earlier component.
    if (cx > best) begin best = cx; pick = COMP_X; end
    if (cy > best) begin best = cy; pick = COMP_Y; end
    if (cz > best) begin best = cz; pick = COMP_Z; end
    v = best + (longint'(1) << FRAC_BITS);
    if (v < 0) v = 0;
    big = floor_root(longint'(v) << (FRAC_BITS - 2));
    bigw = (big > smax) ? word_t'(smax) : word_t'(big);
    case (pick)
      COMP_W: begin
        r.x = scaled_quotient(e[7] - e[5], big);
        r.y = scaled_quotient(e[2] - e[6], big);
        r.z = scaled_quotient(e[3] - e[1], big);
        r.w = bigw;
      end
      COMP_X: begin
        r.x = bigw;
        r.y = scaled_quotient(e[3] + e[1], big);
        r.z = scaled_quotient(e[2] + e[6], big);
        r.w = scaled_quotient(e[7] - e[5], big);
      end
      COMP_Y: begin
        r.x = scaled_quotient(e[3] + e[1], big);
        r.y = bigw;
        r.z = scaled_quotient(e[7] + e[5], big);
        r.w = scaled_quotient(e[2] - e[6], big);
      end
      default: begin
        r.x = scaled_quotient(e[2] + e[6], big);
        r.y = scaled_quotient(e[7] + e[5], big);
        r.z = bigw;
        r.w = scaled_quotient(e[3] - e[1], big);
      end
    endcase
    r.deg = (big == 0);
    return r;
  endfunction

  function automatic bit idle_now();
    // A long quiet window with no idling on either side.
    if (cycle >= 500 && cycle < 900) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  // Random matrix: full-range noise, near rotations or tied diagonals.
  function automatic void random_matrix(output word_t m [9]);
    int kind, dom;
    kind = $urandom_range(9);
    dom = $urandom_range(3);
    for (int i = 0; i < 9; i++) m[i] = word_t'($urandom);
    if (kind >= 4 && kind < 8) begin
      for (int i = 0; i < 9; i++) m[i] = word_t'($signed($urandom_range(8000)) - 4000);
      // Diagonal shaped so a chosen component dominates.
      for (int d = 0; d < 3; d++)
        m[d*4] = word_t'((dom == 0 || dom == d + 1) ? 16384 - $urandom_range(3000)
                                                    : -16384 + $urandom_range(3000));
    end else if (kind >= 8) begin
      m[0] = word_t'($urandom);
      m[4] = ($urandom_range(1)) ? m[0] : -m[0];
      m[8] = ($urandom_range(1)) ? m[0] : -m[0];
    end
  endfunction

  // Offer one matrix and hold it until the block takes it.
  task automatic send_matrix(word_t m [9], bit known, quat_t q);
    if (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) mat[i] <= m[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_quats.push_back(known ? q : shepperd_quat(m));
  endtask

  // Result side: random stall and the check of each accepted beat.
  always @(posedge clk) begin
    quat_t e;
    cycle <= cycle + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quats.size() == 0) begin
        $error("quaternion beat with nothing expected");
        errors++;
      end else begin
        e = pending_quats.pop_front();
        if (out_quat_x !== e.x) begin
          $error("quat_x expected %0d actual %0d", e.x, out_quat_x); errors++;
        end
        if (out_quat_y !== e.y) begin
          $error("quat_y expected %0d actual %0d", e.y, out_quat_y); errors++;
        end
        if (out_quat_z !== e.z) begin
          $error("quat_z expected %0d actual %0d", e.z, out_quat_z); errors++;
        end
        if (out_quat_w !== e.w) begin
          $error("quat_w expected %0d actual %0d", e.w, out_quat_w); errors++;
        end
        if (out_degenerate !== e.deg) begin
          $error("degenerate expected %0d actual %0d", e.deg, out_degenerate); errors++;
        end
      end
    end
    out_stall <= rst_n && !sending_done ? idle_now() : (rst_n ? idle_now() : 1'b0);
  end

  initial begin
    row_t  rows [$];
    row_t  r;
    word_t m [9];
    quat_t none;
    none = '{x: 0, y: 0, z: 0, w: 0, deg: 0};

    // Hand-checked rows: identity, zero, half turns about each axis.
    r.known = 1'b1;
    r.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    r.q = '{x: 0, y: 0, z: 0, w: 16384, deg: 0}; rows.push_back(r);
    r.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    r.q = '{x: 0, y: 0, z: 0, w: 8192, deg: 0}; rows.push_back(r);
    r.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    r.q = '{x: 16384, y: 0, z: 0, w: 0, deg: 0}; rows.push_back(r);
    r.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    r.q = '{x: 0, y: 16384, z: 0, w: 0, deg: 0}; rows.push_back(r);
    r.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    r.q = '{x: 0, y: 0, z: 16384, w: 0, deg: 0}; rows.push_back(r);
    // Extremes, saturation and ties, checked against the predictor.
    r.known = 1'b0;
    r.q = none;
    r.m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    rows.push_back(r);
    r.m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    rows.push_back(r);
    r.m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    rows.push_back(r);
    r.m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    rows.push_back(r);
    r.m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
    rows.push_back(r);
    r.m = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
    rows.push_back(r);
    r.m = '{-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768, 16384};
    rows.push_back(r);
    r.m = '{0, 100, -100, 200, 0, -300, 400, 500, 0};
    rows.push_back(r);
    r.m = '{8192, 12000, 0, -12000, 8192, 0, 0, 0, 16384};
    rows.push_back(r);
    r.m = '{-8192, 1, 2, 3, 8192, 4, 5, 6, -8192};
    rows.push_back(r);
    r.m = '{-16384, 32767, 32767, 32767, 16384, -32768, -32768, -32768, -16384};
    rows.push_back(r);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_matrix(rows[i].m, rows[i].known, rows[i].q);
    for (int n = 0; n < N_RANDOM; n++) begin
      random_matrix(m);
      send_matrix(m, 1'b0, none);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_to_quaternion verification clean");
    end else begin
      $display("rotation_to_quaternion verification failed");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #2000000;
    $display("rotation_to_quaternion verification failed");
    $finish;
  end

endmodule
